@@ rtl/tdp_pkg.sv @@
// Shared types and constants for the trial division primality tester.
package tdp_pkg;

    localparam int FIRST_DIVISOR = 2;

    typedef struct packed {
        logic load;
    } tdp_rem_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } tdp_rem_sts_t;

endpackage

@@ rtl/tdp_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle, MSB first.
module tdp_rem
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdp_rem_ctl_t         ctl,
    input  logic [NUM_WIDTH-1:0] dividend,
    input  logic [NUM_WIDTH-1:0] divisor,
    output tdp_rem_sts_t         sts
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] shift_reg;
    logic [NUM_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH-1:0] rem_next;
    logic [NUM_WIDTH-1:0] divisor_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [NUM_WIDTH:0]   trial;

    always_comb
    begin
        trial = {rem_reg, shift_reg[NUM_WIDTH-1]};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = NUM_WIDTH'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[NUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.load)
            begin
                cnt_reg <= CNT_W'(NUM_WIDTH);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            shift_reg   <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
        end
        else if (run_reg)
        begin
            shift_reg <= {shift_reg[NUM_WIDTH-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

endmodule

@@ rtl/trial_division_primality.sv @@
// Trial division primality tester: top level with the divisor sequencer.
//
// Pulse start while busy is low to test candidate; busy rises in the next cycle and
// stays high until done pulses for one cycle with is_prime_flag. The receiver
// cannot stall, so the result must be taken in that cycle. Divisors run from 2
// upward while divisor squared does not exceed the candidate; each trial runs
// in the bit-serial remainder unit, and the first divisor that leaves no
// remainder ends the test with the candidate found not prime.
module trial_division_primality
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    output logic                 done,
    output logic                 is_prime_flag
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;

    logic [1:0]           state_reg;
    logic [NUM_WIDTH-1:0] n_reg;
    logic [NUM_WIDTH-1:0] d_reg;
    logic [NUM_WIDTH+1:0] sq_reg;
    logic                 done_reg;
    logic                 flag_reg;
    tdp_rem_ctl_t         rem_ctl;
    tdp_rem_sts_t         rem_sts;

    assign rem_ctl.load = (state_reg == ST_CHECK) && (n_reg >= NUM_WIDTH'(FIRST_DIVISOR))
                          && (sq_reg <= {2'b00, n_reg});

    tdp_rem #(
        .NUM_WIDTH(NUM_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rem_ctl),
        .dividend (n_reg),
        .divisor  (d_reg),
        .sts      (rem_sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (n_reg < NUM_WIDTH'(FIRST_DIVISOR))
                    begin
                        flag_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (sq_reg > {2'b00, n_reg})
                    begin
                        flag_reg  <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (rem_sts.done)
                    begin
                        if (rem_sts.zero)
                        begin
                            flag_reg  <= 1'b0;
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            n_reg  <= candidate;
            d_reg  <= NUM_WIDTH'(FIRST_DIVISOR);
            sq_reg <= (NUM_WIDTH + 2)'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        else if ((state_reg == ST_DIV) && rem_sts.done)
        begin
            d_reg  <= d_reg + NUM_WIDTH'(1);
            sq_reg <= sq_reg + {1'b0, d_reg, 1'b1};
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign is_prime_flag = flag_reg;

endmodule
